// File: design/sise_pkg.sv
// Shared constants, codes and types of the sorted item set engine.
`default_nettype none
package sise_pkg;

    localparam int SET_DEPTH = 32;
    localparam int IDX_W     = $clog2(SET_DEPTH);
    localparam int CNT_W     = $clog2(SET_DEPTH + 1);
    localparam int VAL_W     = 16;
    localparam int POS_W     = 16;

    localparam logic [2:0] ACT_INSERT = 3'd0;
    localparam logic [2:0] ACT_REMOVE = 3'd1;
    localparam logic [2:0] ACT_LOOKUP = 3'd2;
    localparam logic [2:0] ACT_CLEAR  = 3'd3;
    localparam logic [2:0] ACT_ELEM   = 3'd4;

    localparam logic [2:0] OP_INTERSECTS = 3'd0;
    localparam logic [2:0] OP_SUBSET     = 3'd1;
    localparam logic [2:0] OP_EQUALS     = 3'd2;
    localparam logic [2:0] OP_LEXCMP     = 3'd3;
    localparam logic [2:0] OP_INTERSECT  = 3'd4;
    localparam logic [2:0] OP_UNITE      = 3'd5;
    localparam logic [2:0] OP_SUBTRACT   = 3'd6;

    localparam logic [1:0] DEC_NONE    = 2'd0;
    localparam logic [1:0] DEC_GREATER = 2'd1;
    localparam logic [1:0] DEC_LESS    = 2'd2;

    localparam logic [1:0] ORD_EQUAL   = 2'b00;
    localparam logic [1:0] ORD_GREATER = 2'b01;
    localparam logic [1:0] ORD_LESS    = 2'b11;

    localparam logic [2:0] CMD_HOLD    = 3'd0;
    localparam logic [2:0] CMD_INSERT  = 3'd1;
    localparam logic [2:0] CMD_REMOVE  = 3'd2;
    localparam logic [2:0] CMD_MARK    = 3'd3;
    localparam logic [2:0] CMD_COMPACT = 3'd4;

    localparam logic [0:0] REG_PAIR_OP = 1'b0;

    typedef struct packed {
        logic [2:0]       cmd;
        logic             clr;
        logic [VAL_W-1:0] value;
        logic [CNT_W-1:0] count;
        logic [POS_W-1:0] pos;
    } cell_ctrl_t;

endpackage
`default_nettype wire

// File: design/sorted_item_set_engine_top.sv
// Top level of the sorted item set engine: cell row, control and ports.
`default_nettype none
// Usage:
//   Input words arrive on s_tvalid/s_tready/s_tdata/s_tlast. s_tdata holds
//   action [2:0] and value [18:3]; s_tlast marks the final element of set B.
//   Every accepted word yields exactly one result word on
//   m_tvalid/m_tready/m_tdata (answer, order, set_size, refused).
//   All cells in the row compare against the value at once and shift,
//   insert or mark in the same edge that accepts the word, and the result
//   is registered by that edge too.
//   The last B element of an in-place intersection starts a compaction pass
//   that drops one unmarked entry per cycle; its result word is registered
//   once no unmatched entry is left.
//   One word is in flight at a time; s_tready is high when no compaction
//   runs and the output register is empty or being emptied.
//   A stalled receiver holds the result in the output register and blocks
//   further input until it is taken.
//   Reset empties the set, clears all marks and stream state and selects
//   the intersects test; no clearing pass is needed.
//   The APB port holds pair_operation at address 0.
module sorted_item_set_engine_top (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,   // action [2:0], value [18:3], zero fill
    input  wire logic        s_tlast,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata    // answer [0], order [2:1], set_size [8:3],
                                        // refused [9], zero fill
);
    localparam int D  = sise_pkg::SET_DEPTH;
    localparam int CW = sise_pkg::CNT_W;
    localparam int PW = sise_pkg::POS_W;

    localparam logic ST_IDLE    = 1'b0;
    localparam logic ST_COMPACT = 1'b1;

    logic [2:0]    op_reg;
    logic          state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] total_reg, total_next;
    logic [PW-1:0] pos_reg, pos_next;
    logic [1:0]    dec_reg, dec_next;
    logic          ovalid_reg, ovalid_next;
    logic [9:0]    odata_reg, odata_next;

    logic [2:0]                action;
    logic [sise_pkg::VAL_W-1:0] value;
    logic                      s_fire;
    sise_pkg::cell_ctrl_t      ctrl;

    logic [sise_pkg::VAL_W-1:0] item_w [D];
    logic [D-1:0] mark_w, lt_w, eq_w, hole_w, plt_w, pgt_w;

    logic hit, hit_mark, any_hole;
    logic answer, refused;
    logic [1:0] order;
    logic [PW:0] n_elem;

    assign action = s_tdata[2:0];
    assign value  = s_tdata[18:3];
    assign s_tready = (state_reg == ST_IDLE) && (!ovalid_reg || m_tready);
    assign s_fire   = s_tvalid && s_tready;

    // Configuration: single register, written on the APB access phase.
    assign pready = 1'b1;
    assign prdata = (paddr[2] == sise_pkg::REG_PAIR_OP) ? {29'd0, op_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            op_reg <= sise_pkg::OP_INTERSECTS;
        else if (psel && penable && pwrite && pready && paddr[2] == sise_pkg::REG_PAIR_OP)
            op_reg <= pwdata[2:0];
    end

    // Row of cells; each hands item and mark to its neighbours.
    genvar gi;
    generate
        for (gi = 0; gi < D; gi++)
        begin : g_cell
            logic                       p_lt, p_mark, p_hole, n_mark;
            logic [sise_pkg::VAL_W-1:0] p_item, n_item;
            if (gi == 0)
            begin : g_first
                assign p_lt   = 1'b1;
                assign p_item = '0;
                assign p_mark = 1'b0;
                assign p_hole = 1'b0;
            end
            else
            begin : g_mid
                assign p_lt   = lt_w[gi-1];
                assign p_item = item_w[gi-1];
                assign p_mark = mark_w[gi-1];
                assign p_hole = hole_w[gi-1];
            end
            if (gi == D - 1)
            begin : g_top
                assign n_item = '0;
                assign n_mark = 1'b0;
            end
            else
            begin : g_low
                assign n_item = item_w[gi+1];
                assign n_mark = mark_w[gi+1];
            end
            sise_cell u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .idx       (sise_pkg::IDX_W'(gi)),
                .ctrl      (ctrl),
                .prev_lt   (p_lt),
                .prev_item (p_item),
                .prev_mark (p_mark),
                .prev_hole (p_hole),
                .next_item (n_item),
                .next_mark (n_mark),
                .item      (item_w[gi]),
                .mark      (mark_w[gi]),
                .lt        (lt_w[gi]),
                .eq        (eq_w[gi]),
                .hole      (hole_w[gi]),
                .at_pos_lt (plt_w[gi]),
                .at_pos_gt (pgt_w[gi])
            );
        end
    endgenerate

    assign hit      = |eq_w;
    assign hit_mark = |(eq_w & mark_w);
    assign any_hole = hole_w[D-1];

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        total_next  = total_reg;
        pos_next    = pos_reg;
        dec_next    = dec_reg;
        ovalid_next = ovalid_reg && !m_tready;
        odata_next  = odata_reg;
        answer      = 1'b0;
        order       = sise_pkg::ORD_EQUAL;
        refused     = 1'b0;
        n_elem      = {1'b0, pos_reg} + 1'b1;
        ctrl.cmd    = sise_pkg::CMD_HOLD;
        ctrl.clr    = 1'b0;
        ctrl.value  = value;
        ctrl.count  = count_reg;
        ctrl.pos    = pos_reg;

        if (state_reg == ST_COMPACT)
        begin
            if (any_hole)
            begin
                // drop the lowest unmatched entry
                ctrl.cmd   = sise_pkg::CMD_COMPACT;
                count_next = count_reg - 1'b1;
            end
            else
            begin
                ctrl.clr    = 1'b1;
                total_next  = '0;
                pos_next    = '0;
                dec_next    = sise_pkg::DEC_NONE;
                state_next  = ST_IDLE;
                ovalid_next = 1'b1;
                odata_next  = {1'b0, count_reg, sise_pkg::ORD_EQUAL, 1'b0};
            end
        end
        else if (s_fire)
        begin
            case (action)
                sise_pkg::ACT_INSERT:
                begin
                    if (!hit)
                    begin
                        if (count_reg >= CW'(D))
                            refused = 1'b1;
                        else
                        begin
                            ctrl.cmd   = sise_pkg::CMD_INSERT;
                            count_next = count_reg + 1'b1;
                        end
                    end
                    ctrl.clr = 1'b1;
                    total_next = '0;
                    pos_next   = '0;
                    dec_next   = sise_pkg::DEC_NONE;
                end
                sise_pkg::ACT_REMOVE:
                begin
                    if (hit)
                    begin
                        ctrl.cmd   = sise_pkg::CMD_REMOVE;
                        count_next = count_reg - 1'b1;
                    end
                    ctrl.clr = 1'b1;
                    total_next = '0;
                    pos_next   = '0;
                    dec_next   = sise_pkg::DEC_NONE;
                end
                sise_pkg::ACT_LOOKUP:
                begin
                    answer = hit;
                end
                sise_pkg::ACT_CLEAR:
                begin
                    count_next = '0;
                    ctrl.clr   = 1'b1;
                    total_next = '0;
                    pos_next   = '0;
                    dec_next   = sise_pkg::DEC_NONE;
                end
                sise_pkg::ACT_ELEM:
                begin
                    // lexicographic decision against the entry at the stream position
                    if (dec_reg == sise_pkg::DEC_NONE)
                    begin
                        if (!({{(PW-CW){1'b0}}, count_reg} > pos_reg))
                            dec_next = sise_pkg::DEC_LESS;
                        else if (|plt_w)
                            dec_next = sise_pkg::DEC_LESS;
                        else if (|pgt_w)
                            dec_next = sise_pkg::DEC_GREATER;
                    end
                    if (op_reg == sise_pkg::OP_SUBTRACT)
                    begin
                        if (hit)
                        begin
                            ctrl.cmd   = sise_pkg::CMD_REMOVE;
                            count_next = count_reg - 1'b1;
                            if (hit_mark && total_reg != '0)
                                total_next = total_reg - 1'b1;
                        end
                    end
                    else if (hit)
                    begin
                        if (!hit_mark)
                        begin
                            ctrl.cmd   = sise_pkg::CMD_MARK;
                            total_next = total_reg + 1'b1;
                        end
                    end
                    else if (op_reg == sise_pkg::OP_UNITE)
                    begin
                        if (count_reg >= CW'(D))
                            refused = 1'b1;
                        else
                        begin
                            ctrl.cmd   = sise_pkg::CMD_INSERT;
                            count_next = count_reg + 1'b1;
                        end
                    end
                    if (pos_reg != {PW{1'b1}})
                        pos_next = pos_reg + 1'b1;
                    if (s_tlast)
                    begin
                        case (op_reg)
                            sise_pkg::OP_INTERSECTS:
                                answer = total_next != '0;
                            sise_pkg::OP_SUBSET:
                                answer = {{(PW+1-CW){1'b0}}, total_next} == n_elem;
                            sise_pkg::OP_EQUALS:
                                answer = ({{(PW+1-CW){1'b0}}, count_next} == n_elem)
                                         && (total_next == count_next);
                            sise_pkg::OP_LEXCMP:
                            begin
                                if (dec_next == sise_pkg::DEC_GREATER)
                                    order = sise_pkg::ORD_GREATER;
                                else if (dec_next == sise_pkg::DEC_LESS)
                                    order = sise_pkg::ORD_LESS;
                                else if ({{(PW+1-CW){1'b0}}, count_next} > n_elem)
                                    order = sise_pkg::ORD_GREATER;
                            end
                            default:
                                answer = 1'b0;
                        endcase
                        if (op_reg == sise_pkg::OP_INTERSECT)
                        begin
                            // keep marks; compaction follows, result held until done
                            state_next = ST_COMPACT;
                        end
                        else
                        begin
                            ctrl.clr   = 1'b1;
                            total_next = '0;
                            pos_next   = '0;
                            dec_next   = sise_pkg::DEC_NONE;
                        end
                    end
                end
                default:
                begin
                    answer = 1'b0;
                end
            endcase
            if (state_next == ST_IDLE)
            begin
                ovalid_next = 1'b1;
                odata_next  = {refused, count_next, order, answer};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            count_reg  <= '0;
            total_reg  <= '0;
            pos_reg    <= '0;
            dec_reg    <= sise_pkg::DEC_NONE;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            total_reg  <= total_next;
            pos_reg    <= pos_next;
            dec_reg    <= dec_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        odata_reg <= odata_next;
    end

    assign m_tvalid = ovalid_reg;
    assign m_tdata  = {6'd0, odata_reg};

    // Set never grows past its depth.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(D))
        else $error("set count beyond depth");

    // Matched total never exceeds the number of entries.
    a_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
        total_reg <= count_reg)
        else $error("match total beyond set count");

    // No word is taken while compaction runs.
    a_compact_block: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_COMPACT) |-> !s_tready)
        else $error("input taken during compaction");

    // An accepted clear empties the set.
    a_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (s_fire && action == sise_pkg::ACT_CLEAR) |=> (count_reg == '0))
        else $error("clear did not empty the set");
endmodule
`default_nettype wire

// File: design/sise_cell.sv
// One storage cell of the set: item, match mark and local compares.
`default_nettype none
module sise_cell (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic [sise_pkg::IDX_W-1:0]     idx,
    input  wire sise_pkg::cell_ctrl_t           ctrl,
    input  wire logic                           prev_lt,
    input  wire logic [sise_pkg::VAL_W-1:0]     prev_item,
    input  wire logic                           prev_mark,
    input  wire logic                           prev_hole,
    input  wire logic [sise_pkg::VAL_W-1:0]     next_item,
    input  wire logic                           next_mark,
    output logic [sise_pkg::VAL_W-1:0]          item,
    output logic                                mark,
    output logic                                lt,
    output logic                                eq,
    output logic                                hole,
    output logic                                at_pos_lt,
    output logic                                at_pos_gt
);
    logic [sise_pkg::VAL_W-1:0] item_reg, item_next;
    logic                       mark_reg, mark_next;
    logic                       occ, at_pos;

    assign occ    = {1'b0, idx} < ctrl.count;
    assign at_pos = {{(sise_pkg::POS_W-sise_pkg::IDX_W){1'b0}}, idx} == ctrl.pos;
    assign lt     = occ && (item_reg < ctrl.value);
    assign eq     = occ && (item_reg == ctrl.value);
    assign hole   = prev_hole || (occ && !mark_reg);
    assign at_pos_lt = at_pos && (item_reg < ctrl.value);
    assign at_pos_gt = at_pos && (item_reg > ctrl.value);
    assign item = item_reg;
    assign mark = mark_reg;

    always_comb
    begin
        item_next = item_reg;
        mark_next = mark_reg;
        case (ctrl.cmd)
            sise_pkg::CMD_INSERT:
            begin
                if (!lt)
                begin
                    if (prev_lt)
                    begin
                        item_next = ctrl.value;
                        mark_next = 1'b0;
                    end
                    else
                    begin
                        item_next = prev_item;
                        mark_next = prev_mark;
                    end
                end
            end
            sise_pkg::CMD_REMOVE:
            begin
                if (!lt)
                begin
                    item_next = next_item;
                    mark_next = next_mark;
                end
            end
            sise_pkg::CMD_MARK:
            begin
                if (eq)
                    mark_next = 1'b1;
            end
            sise_pkg::CMD_COMPACT:
            begin
                if (hole)
                begin
                    item_next = next_item;
                    mark_next = next_mark;
                end
            end
            default:
            begin
                item_next = item_reg;
            end
        endcase
        if (ctrl.clr)
            mark_next = 1'b0;
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mark_reg <= 1'b0;
        else
            mark_reg <= mark_next;
    end
endmodule
`default_nettype wire

// File: sim/tb.sv
// Self-checking bench for the sorted item set engine: directed table, random words, APB setup.
module tb;

    localparam int WATCHDOG_LIMIT = 20000;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;   // action [2:0], value [18:3], zero fill
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;   // answer [0], order [2:1], set_size [8:3], refused [9], zero fill

    sorted_item_set_engine_top u_dut (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    typedef struct packed {
        logic       answer;
        logic [1:0] order;
        logic [5:0] set_size;
        logic       refused;
    } verdict_t;

    // Directed rows; has_exp marks rows whose verdict is typed in by hand.
    typedef struct {
        logic [2:0]  action;
        logic [15:0] value;
        logic        last;
        logic        has_exp;
        verdict_t    exp;
    } row_t;

    // Shadow of the set held by the block
    logic [15:0] set_items [sise_pkg::SET_DEPTH];
    logic        set_marks [sise_pkg::SET_DEPTH];
    int          set_count;
    int          b_seen;
    int          b_matched;
    logic [1:0]  b_order;
    logic [2:0]  pair_op;

    verdict_t    verdict_q [$];
    bit          failed;
    int          idle_pct_s;
    int          idle_pct_m;
    bit          hold_off;
    int          quiet_cycles;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Drop all stream state, as the block does when a B run ends.
    function automatic void drop_stream();
        for (int i = 0; i < sise_pkg::SET_DEPTH; i++)
            set_marks[i] = 1'b0;
        b_seen    = 0;
        b_matched = 0;
        b_order   = sise_pkg::DEC_NONE;
    endfunction

    function automatic void shift_in(int at, logic [15:0] v);
        for (int k = set_count; k > at; k--)
        begin
            set_items[k] = set_items[k-1];
            set_marks[k] = set_marks[k-1];
        end
        set_items[at] = v;
        set_marks[at] = 1'b0;
        set_count++;
    endfunction

    function automatic void shift_out(int at);
        if (set_marks[at] && b_matched > 0)
            b_matched--;
        for (int k = at; k + 1 < set_count; k++)
        begin
            set_items[k] = set_items[k+1];
            set_marks[k] = set_marks[k+1];
        end
        set_count--;
        set_marks[set_count] = 1'b0;
    endfunction

    // Work out the verdict of one accepted word and advance the shadow set.
    function automatic verdict_t predict_set_step(logic [2:0] act, logic [15:0] v, logic lst);
        verdict_t r;
        int  at;
        int  n;
        int  k;
        bit  hit;
        r  = '0;
        at = 0;
        while (at < set_count && set_items[at] < v)
            at++;
        hit = (at < set_count) && (set_items[at] == v);
        case (act)
            sise_pkg::ACT_INSERT:
            begin
                if (!hit)
                begin
                    if (set_count >= sise_pkg::SET_DEPTH)
                        r.refused = 1'b1;
                    else
                        shift_in(at, v);
                end
                drop_stream();
            end
            sise_pkg::ACT_REMOVE:
            begin
                if (hit)
                    shift_out(at);
                drop_stream();
            end
            sise_pkg::ACT_LOOKUP:
                r.answer = hit;
            sise_pkg::ACT_CLEAR:
            begin
                set_count = 0;
                drop_stream();
            end
            sise_pkg::ACT_ELEM:
            begin
                n = b_seen + 1;
                if (b_order == sise_pkg::DEC_NONE)
                begin
                    if (b_seen >= set_count)
                        b_order = sise_pkg::DEC_LESS;
                    else if (set_items[b_seen] < v)
                        b_order = sise_pkg::DEC_LESS;
                    else if (set_items[b_seen] > v)
                        b_order = sise_pkg::DEC_GREATER;
                end
                if (pair_op == sise_pkg::OP_SUBTRACT)
                begin
                    if (hit)
                        shift_out(at);
                end
                else if (hit)
                begin
                    if (!set_marks[at])
                    begin
                        set_marks[at] = 1'b1;
                        b_matched++;
                    end
                end
                else if (pair_op == sise_pkg::OP_UNITE)
                begin
                    if (set_count >= sise_pkg::SET_DEPTH)
                        r.refused = 1'b1;
                    else
                        shift_in(at, v);
                end
                if (b_seen < 65535)
                    b_seen++;
                if (lst)
                begin
                    case (pair_op)
                        sise_pkg::OP_INTERSECTS: r.answer = (b_matched > 0);
                        sise_pkg::OP_SUBSET:     r.answer = (b_matched == n);
                        sise_pkg::OP_EQUALS:
                            r.answer = (n == set_count) && (b_matched == set_count);
                        sise_pkg::OP_LEXCMP:
                        begin
                            if (b_order == sise_pkg::DEC_GREATER)
                                r.order = sise_pkg::ORD_GREATER;
                            else if (b_order == sise_pkg::DEC_LESS)
                                r.order = sise_pkg::ORD_LESS;
                            else
                                r.order = (set_count > n) ? sise_pkg::ORD_GREATER
                                                          : sise_pkg::ORD_EQUAL;
                        end
                        sise_pkg::OP_INTERSECT:
                        begin
                            k = 0;
                            for (int i = 0; i < set_count; i++)
                                if (set_marks[i])
                                begin
                                    set_items[k] = set_items[i];
                                    k++;
                                end
                            set_count = k;
                        end
                        default: ;
                    endcase
                    drop_stream();
                end
            end
            default: ;
        endcase
        r.set_size = set_count[5:0];
        return r;
    endfunction

    // Offer one word, hold it until taken, and queue its verdict.
    task automatic send_word(logic [2:0] act, logic [15:0] v, logic lst,
                             bit has_exp, verdict_t exp);
        verdict_t p;
        while ($urandom_range(99) < idle_pct_s)
            @(negedge clk);
        s_tvalid = 1'b1;
        s_tdata  = {5'd0, v, act};
        s_tlast  = lst;
        // ready is settled between the falling edge and the next rising edge
        #1;
        while (!s_tready)
        begin
            @(negedge clk);
            #1;
        end
        @(posedge clk);
        p = predict_set_step(act, v, lst);
        if (has_exp && p != exp)
        begin
            $display("%0t: table row disagrees, exp %h got %h", $time, exp, p);
            failed = 1'b1;
        end
        verdict_q.push_back(has_exp ? exp : p);
        @(negedge clk);
        s_tvalid = 1'b0;
    endtask

    task automatic write_pair_op(logic [2:0] op);
        // let any compaction finish before touching the register
        while (verdict_q.size() != 0)
            @(negedge clk);
        repeat (sise_pkg::SET_DEPTH + 4) @(negedge clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        paddr   <= 3'd0;
        pwdata  <= {29'd0, op};
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        pair_op = op;
    endtask

    // Run of B with random length, mostly drawn from A; order and repeats are random.
    task automatic send_b_run(int len);
        logic [15:0] v;
        v = 16'($urandom_range(3));
        for (int i = 0; i < len; i++)
        begin
            if (set_count > 0 && $urandom_range(2) != 0)
                v = set_items[$urandom_range(set_count - 1)];
            else
                v = 16'($urandom);
            send_word(sise_pkg::ACT_ELEM, v, (i == len - 1), 1'b0, '0);
        end
    endtask

    // Sink: random stalls, plus a long hold-off on request.
    always @(negedge clk)
    begin
        if (!rst_n || hold_off)
            m_tready <= 1'b0;
        else
            m_tready <= ($urandom_range(99) >= idle_pct_m);
    end

    // Check every result word against the oldest queued verdict.
    always
    begin
        verdict_t got;
        verdict_t exp;
        logic     take;
        // outputs are settled after the falling edge; the handshake is at the rising edge
        @(negedge clk);
        #1;
        take = rst_n && m_tvalid && m_tready;
        got  = {m_tdata[0], m_tdata[2:1], m_tdata[8:3], m_tdata[9]};
        @(posedge clk);
        if (take && rst_n)
        begin
            if (verdict_q.size() == 0)
            begin
                $display("%0t: unexpected result %h", $time, got);
                failed = 1'b1;
            end
            else
            begin
                exp = verdict_q.pop_front();
                if (got.answer !== exp.answer || got.order !== exp.order ||
                    got.set_size !== exp.set_size || got.refused !== exp.refused)
                begin
                    $display("%0t: mismatch exp %h got %h", $time, exp, got);
                    failed = 1'b1;
                end
            end
        end
    end

    // Watchdog: count cycles with no handshake on either side.
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > WATCHDOG_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    // Directed rows: empty set, extremes, a repeated insert, B runs under the intersects test, unused codes, clear.
    row_t table_rows [] = '{
        '{sise_pkg::ACT_LOOKUP, 16'h0000, 1'b0, 1'b1, '{1'b0, 2'b00, 6'd0, 1'b0}},
        '{sise_pkg::ACT_REMOVE, 16'hFFFF, 1'b0, 1'b1, '{1'b0, 2'b00, 6'd0, 1'b0}},
        '{sise_pkg::ACT_INSERT, 16'hFFFF, 1'b0, 1'b1, '{1'b0, 2'b00, 6'd1, 1'b0}},
        '{sise_pkg::ACT_INSERT, 16'h0000, 1'b0, 1'b1, '{1'b0, 2'b00, 6'd2, 1'b0}},
        '{sise_pkg::ACT_INSERT, 16'h0000, 1'b0, 1'b1, '{1'b0, 2'b00, 6'd2, 1'b0}},
        '{sise_pkg::ACT_LOOKUP, 16'hFFFF, 1'b0, 1'b1, '{1'b1, 2'b00, 6'd2, 1'b0}},
        '{sise_pkg::ACT_LOOKUP, 16'h5555, 1'b0, 1'b1, '{1'b0, 2'b00, 6'd2, 1'b0}},
        '{sise_pkg::ACT_REMOVE, 16'h1234, 1'b0, 1'b1, '{1'b0, 2'b00, 6'd2, 1'b0}},
        '{sise_pkg::ACT_ELEM,   16'h0000, 1'b0, 1'b0, '0},
        '{sise_pkg::ACT_LOOKUP, 16'h0000, 1'b0, 1'b0, '0},
        '{sise_pkg::ACT_ELEM,   16'hFFFF, 1'b1, 1'b0, '0},
        '{sise_pkg::ACT_ELEM,   16'h0000, 1'b0, 1'b0, '0},
        '{sise_pkg::ACT_INSERT, 16'hAAAA, 1'b0, 1'b0, '0},
        '{sise_pkg::ACT_ELEM,   16'hAAAA, 1'b0, 1'b0, '0},
        '{sise_pkg::ACT_ELEM,   16'hAAAA, 1'b1, 1'b0, '0},
        '{3'd5,                 16'h1111, 1'b1, 1'b0, '0},
        '{3'd6,                 16'h2222, 1'b0, 1'b0, '0},
        '{3'd7,                 16'h3333, 1'b1, 1'b0, '0},
        '{sise_pkg::ACT_CLEAR,  16'h0000, 1'b0, 1'b1, '{1'b0, 2'b00, 6'd0, 1'b0}}
    };

    initial
    begin
        int pn;
        rst_n    = 1'b0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tlast  = 1'b0;
        m_tready = 1'b0;
        hold_off = 1'b0;
        failed   = 1'b0;
        idle_pct_s = 0;
        idle_pct_m = 0;
        set_count  = 0;
        pair_op    = sise_pkg::OP_INTERSECTS;
        quiet_cycles = 0;
        for (int i = 0; i < sise_pkg::SET_DEPTH; i++)
            set_items[i] = '0;
        drop_stream();
        repeat (4) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (table_rows[i])
            send_word(table_rows[i].action, table_rows[i].value, table_rows[i].last,
                      table_rows[i].has_exp, table_rows[i].exp);

        // Fill to saturation, then refuse an extra insert.
        for (int i = 0; i < sise_pkg::SET_DEPTH; i++)
            send_word(sise_pkg::ACT_INSERT, 16'(i * 2000 + 7), 1'b0, 1'b0, '0);
        send_word(sise_pkg::ACT_INSERT, 16'h0001, 1'b0, 1'b1, '{1'b0, 2'b00, 6'd32, 1'b1});

        // Random phases; operation walks all codes including the unused one.
        for (int phase = 0; phase < 16; phase++)
        begin
            case (phase % 4)
                0: begin idle_pct_s = 0;  idle_pct_m = 0;  end
                1: begin idle_pct_s = 71; idle_pct_m = 0;  end
                2: begin idle_pct_s = 0;  idle_pct_m = 71; end
                default: begin idle_pct_s = 12; idle_pct_m = 12; end
            endcase
            write_pair_op(3'(phase % 8));
            if (phase == 5)
            begin
                // hold the sink off long enough for input to back up
                fork
                    begin
                        hold_off = 1'b1;
                        repeat (60) @(negedge clk);
                        hold_off = 1'b0;
                    end
                join_none
            end
            pn = 0;
            while (pn < 30)
            begin
                case ($urandom_range(9))
                    0, 1:
                    begin
                        send_word(sise_pkg::ACT_INSERT, 16'($urandom), 1'b0, 1'b0, '0);
                        pn++;
                    end
                    2:
                    begin
                        send_word(sise_pkg::ACT_REMOVE, (set_count > 0 && $urandom_range(1)) ?
                                  set_items[$urandom_range(set_count - 1)] : 16'($urandom),
                                  1'b0, 1'b0, '0);
                        pn++;
                    end
                    3:
                    begin
                        send_word(sise_pkg::ACT_LOOKUP, (set_count > 0 && $urandom_range(1)) ?
                                  set_items[$urandom_range(set_count - 1)] : 16'($urandom),
                                  1'($urandom), 1'b0, '0);
                        pn++;
                    end
                    4:
                    begin
                        if ($urandom_range(7) == 0)
                            send_word(sise_pkg::ACT_CLEAR, 16'($urandom), 1'($urandom),
                                      1'b0, '0);
                        else
                            send_word(3'($urandom_range(7)), 16'($urandom), 1'($urandom),
                                      1'b0, '0);
                        pn++;
                    end
                    default:
                    begin
                        pn += 4;
                        send_b_run($urandom_range(1, 8));
                    end
                endcase
            end
        end

        write_pair_op(sise_pkg::OP_SUBTRACT);
        write_pair_op(sise_pkg::OP_INTERSECTS);
        while (verdict_q.size() != 0)
            @(negedge clk);
        repeat (sise_pkg::SET_DEPTH + 10) @(negedge clk);
        if (!failed)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end
endmodule
